@@ rtl/gpioei_pkg.sv @@
// Package for the GPIO port with edge interrupts: widths, pin masks,
// function and register index codes.
// No dependencies.
`default_nettype none

package gpioei_pkg;

  localparam int PIN_COUNT = 16;
  localparam int PINS_W    = 16;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 4;

  localparam int AFL_PINS = (PIN_COUNT > 8) ? 8 : PIN_COUNT;
  localparam int AFH_PINS = (PIN_COUNT > 8) ? PIN_COUNT - 8 : 0;

  localparam logic [PINS_W-1:0] PIN_MASK  = PINS_W'((64'd1 << PIN_COUNT) - 64'd1);
  localparam logic [DATA_W-1:0] PAIR_MASK = DATA_W'((64'd1 << (2 * PIN_COUNT)) - 64'd1);
  localparam logic [DATA_W-1:0] AFL_MASK  = DATA_W'((64'd1 << (4 * AFL_PINS)) - 64'd1);
  localparam logic [DATA_W-1:0] AFH_MASK  = DATA_W'((64'd1 << (4 * AFH_PINS)) - 64'd1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE    = 4'd0,
    REG_OTYPE   = 4'd1,
    REG_SPEED   = 4'd2,
    REG_PULL    = 4'd3,
    REG_INPUT   = 4'd4,
    REG_OUTPUT  = 4'd5,
    REG_AFL     = 4'd6,
    REG_AFH     = 4'd7,
    REG_RISE    = 4'd8,
    REG_FALL    = 4'd9,
    REG_MASK    = 4'd10,
    REG_PENDING = 4'd11
  } reg_idx_t;

endpackage

`default_nettype wire

@@ rtl/gpio_port_with_edge_interrupts_core.sv @@
// GPIO port with edge interrupts: bus register file, pin sampling, edge
// latch and per-pin drive controls. Depends on gpioei_pkg.
//
//   channel  direction  handshake             payload
//   in       to core    in_valid / in_stall   func, reg_index, write_data, pin_levels
//   out      from core  out_valid / out_stall read_data, irq, pin_drive,
//                                             drive_enable, open_drain
//
// One transfer per cycle while out is not stalled; a result passes from its
// input transfer through the input register, then the result register.
// The register file is updated as the item moves from input to result register.
// rst (synchronous) clears the port registers to zero and empties both stages.
// A stall on out holds the result register; in stalls only while the input
// register is full and cannot move on.
`default_nettype none

module gpio_port_with_edge_interrupts_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [gpioei_pkg::FUNC_W-1:0]   func,
  input  wire logic [gpioei_pkg::IDX_W-1:0]    reg_index,
  input  wire logic [gpioei_pkg::DATA_W-1:0]   write_data,
  input  wire logic [gpioei_pkg::PINS_W-1:0]   pin_levels,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [gpioei_pkg::DATA_W-1:0]   read_data,
  output      logic                            irq,
  output      logic [gpioei_pkg::PINS_W-1:0]   pin_drive,
  output      logic [gpioei_pkg::PINS_W-1:0]   drive_enable,
  output      logic [gpioei_pkg::PINS_W-1:0]   open_drain
);
  import gpioei_pkg::*;

  // input register
  logic                s_valid;
  func_t               s_func;
  reg_idx_t            s_idx;
  logic [DATA_W-1:0]   s_wdata;
  logic [PINS_W-1:0]   s_pins;
  logic                s_adv;
  logic                s_fire;

  // port registers
  logic [DATA_W-1:0]   pin_mode,        pin_mode_next;
  logic [PINS_W-1:0]   output_type,     output_type_next;
  logic [DATA_W-1:0]   output_speed,    output_speed_next;
  logic [DATA_W-1:0]   pull_select,     pull_select_next;
  logic [PINS_W-1:0]   input_data,      input_data_next;
  logic [PINS_W-1:0]   output_data,     output_data_next;
  logic [DATA_W-1:0]   alt_low,         alt_low_next;
  logic [DATA_W-1:0]   alt_high,        alt_high_next;
  logic [PINS_W-1:0]   rise_enable,     rise_enable_next;
  logic [PINS_W-1:0]   fall_enable,     fall_enable_next;
  logic [PINS_W-1:0]   irq_mask,        irq_mask_next;
  logic [PINS_W-1:0]   pending,         pending_next;
  logic [PINS_W-1:0]   previous_levels, previous_levels_next;

  logic [PINS_W-1:0]   levels;
  logic [DATA_W-1:0]   rdata;
  logic [PINS_W-1:0]   drive_next;

  assign s_adv    = !out_valid || !out_stall;
  assign s_fire   = s_valid && s_adv;
  assign in_stall = s_valid && !s_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_func  <= func_t'(func);
      s_idx   <= reg_idx_t'(reg_index);
      s_wdata <= write_data;
      s_pins  <= pin_levels;
    end
  end

  assign levels = s_pins & PIN_MASK;

  always_comb begin
    pin_mode_next        = pin_mode;
    output_type_next     = output_type;
    output_speed_next    = output_speed;
    pull_select_next     = pull_select;
    input_data_next      = input_data;
    output_data_next     = output_data;
    alt_low_next         = alt_low;
    alt_high_next        = alt_high;
    rise_enable_next     = rise_enable;
    fall_enable_next     = fall_enable;
    irq_mask_next        = irq_mask;
    pending_next         = pending;
    previous_levels_next = previous_levels;
    rdata                = '0;
    unique case (s_func)
      FUNC_READ: begin
        unique case (s_idx)
          REG_MODE:    rdata = pin_mode;
          REG_OTYPE:   rdata = DATA_W'(output_type);
          REG_SPEED:   rdata = output_speed;
          REG_PULL:    rdata = pull_select;
          REG_INPUT:   rdata = DATA_W'(input_data);
          REG_OUTPUT:  rdata = DATA_W'(output_data);
          REG_AFL:     rdata = alt_low;
          REG_AFH:     rdata = alt_high;
          REG_RISE:    rdata = DATA_W'(rise_enable);
          REG_FALL:    rdata = DATA_W'(fall_enable);
          REG_MASK:    rdata = DATA_W'(irq_mask);
          REG_PENDING: rdata = DATA_W'(pending);
          default:     rdata = '0;
        endcase
      end
      FUNC_WRITE: begin
        unique case (s_idx)
          REG_MODE:    pin_mode_next     = s_wdata & PAIR_MASK;
          REG_OTYPE:   output_type_next  = s_wdata[PINS_W-1:0] & PIN_MASK;
          REG_SPEED:   output_speed_next = s_wdata & PAIR_MASK;
          REG_PULL:    pull_select_next  = s_wdata & PAIR_MASK;
          REG_OUTPUT:  output_data_next  = s_wdata[PINS_W-1:0] & PIN_MASK;
          REG_AFL:     alt_low_next      = s_wdata & AFL_MASK;
          REG_AFH:     alt_high_next     = s_wdata & AFH_MASK;
          REG_RISE:    rise_enable_next  = s_wdata[PINS_W-1:0] & PIN_MASK;
          REG_FALL:    fall_enable_next  = s_wdata[PINS_W-1:0] & PIN_MASK;
          REG_MASK:    irq_mask_next     = s_wdata[PINS_W-1:0] & PIN_MASK;
          REG_PENDING: pending_next      = pending & ~(s_wdata[PINS_W-1:0] & PIN_MASK);
          default:     ;
        endcase
      end
      FUNC_SAMPLE: begin
        pending_next = (pending
                        | (levels & ~previous_levels & rise_enable)
                        | (previous_levels & ~levels & fall_enable)) & PIN_MASK;
        input_data_next      = levels;
        previous_levels_next = levels;
      end
      default: ;
    endcase
  end

  // mode 01 (output) or 10 (alternate function) drives the pin
  always_comb begin
    drive_next = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      drive_next[i] = pin_mode_next[2*i] ^ pin_mode_next[2*i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_mode        <= '0;
      output_type     <= '0;
      output_speed    <= '0;
      pull_select     <= '0;
      input_data      <= '0;
      output_data     <= '0;
      alt_low         <= '0;
      alt_high        <= '0;
      rise_enable     <= '0;
      fall_enable     <= '0;
      irq_mask        <= '0;
      pending         <= '0;
      previous_levels <= '0;
    end else if (s_fire) begin
      pin_mode        <= pin_mode_next;
      output_type     <= output_type_next;
      output_speed    <= output_speed_next;
      pull_select     <= pull_select_next;
      input_data      <= input_data_next;
      output_data     <= output_data_next;
      alt_low         <= alt_low_next;
      alt_high        <= alt_high_next;
      rise_enable     <= rise_enable_next;
      fall_enable     <= fall_enable_next;
      irq_mask        <= irq_mask_next;
      pending         <= pending_next;
      previous_levels <= previous_levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_adv) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      read_data    <= rdata;
      irq          <= |(pending_next & irq_mask_next);
      pin_drive    <= output_data_next;
      drive_enable <= drive_next;
      open_drain   <= output_type_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_irq_tracks_state: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> irq == |(pending & irq_mask))
    else $error("irq does not match pending and mask");

  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_func != FUNC_READ |=> read_data == '0)
    else $error("read_data nonzero on a non-read transfer");

  a_pending_sets_on_sample: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_func != FUNC_SAMPLE |=> (pending & ~$past(pending)) == '0)
    else $error("pending bit set without a sample tick");

  a_pending_in_range: assert property (@(posedge clk) disable iff (rst)
    (pending & ~PIN_MASK) == '0)
    else $error("pending bit set on an unused pin");
`endif

endmodule

`default_nettype wire

@@ sim/tb_gpio_port_with_edge_interrupts_core.sv @@
// Self-checking testbench for gpio_port_with_edge_interrupts_core: register
// access, edge latch and drive controls, checked against an in-bench predictor.
// Depends on gpioei_pkg and the core RTL.
module tb_gpio_port_with_edge_interrupts_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gpioei_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE      = 2'd3;
  localparam logic [IDX_W-1:0]  IDX_UNUSED_LO  = 4'd12;
  localparam logic [IDX_W-1:0]  IDX_UNUSED_HI  = 4'd15;
  localparam logic [1:0]        MODE_OUTPUT    = 2'd1;
  localparam logic [1:0]        MODE_ALTFN     = 2'd2;
  localparam int                STALL_LIMIT    = 2000;
  localparam int                RANDOM_ITEMS   = 1750;
  localparam int                REPORT_MAX     = 100;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic [PINS_W-1:0] pin_drive;
    logic [PINS_W-1:0] drive_enable;
    logic [PINS_W-1:0] open_drain;
  } port_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func = FUNC_READ;
  logic [IDX_W-1:0]  reg_index = REG_MODE;
  logic [DATA_W-1:0] write_data = '0;
  logic [PINS_W-1:0] pin_levels = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] read_data;
  logic              irq;
  logic [PINS_W-1:0] pin_drive;
  logic [PINS_W-1:0] drive_enable;
  logic [PINS_W-1:0] open_drain;

  // predicted register file
  logic [DATA_W-1:0] st_mode = '0;
  logic [PINS_W-1:0] st_otype = '0;
  logic [DATA_W-1:0] st_speed = '0;
  logic [DATA_W-1:0] st_pull = '0;
  logic [PINS_W-1:0] st_input = '0;
  logic [PINS_W-1:0] st_output = '0;
  logic [DATA_W-1:0] st_afl = '0;
  logic [DATA_W-1:0] st_afh = '0;
  logic [PINS_W-1:0] st_rise = '0;
  logic [PINS_W-1:0] st_fall = '0;
  logic [PINS_W-1:0] st_mask = '0;
  logic [PINS_W-1:0] st_pending = '0;
  logic [PINS_W-1:0] st_prev = '0;

  port_result_t awaited[$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  int           rx_hold_cycles = 0;
  bit           tx_idle = 1'b1;
  bit           rx_idle = 1'b1;

  gpio_port_with_edge_interrupts_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .reg_index(reg_index),
    .write_data(write_data),
    .pin_levels(pin_levels),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .irq(irq),
    .pin_drive(pin_drive),
    .drive_enable(drive_enable),
    .open_drain(open_drain)
  );

  always #5 clk = ~clk;

  function automatic port_result_t port_access(input logic [FUNC_W-1:0] f,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [DATA_W-1:0] wd,
                                               input logic [PINS_W-1:0] lv);
    port_result_t      r;
    logic [PINS_W-1:0] lvls;
    logic [PINS_W-1:0] wpins;
    logic [PINS_W-1:0] edges;
    logic [1:0]        pm;
    r = '0;
    lvls = lv & PIN_MASK;
    wpins = wd[PINS_W-1:0] & PIN_MASK;
    case (f)
      FUNC_READ: begin
        case (idx)
          REG_MODE:    r.read_data = st_mode;
          REG_OTYPE:   r.read_data = DATA_W'(st_otype);
          REG_SPEED:   r.read_data = st_speed;
          REG_PULL:    r.read_data = st_pull;
          REG_INPUT:   r.read_data = DATA_W'(st_input);
          REG_OUTPUT:  r.read_data = DATA_W'(st_output);
          REG_AFL:     r.read_data = st_afl;
          REG_AFH:     r.read_data = st_afh;
          REG_RISE:    r.read_data = DATA_W'(st_rise);
          REG_FALL:    r.read_data = DATA_W'(st_fall);
          REG_MASK:    r.read_data = DATA_W'(st_mask);
          REG_PENDING: r.read_data = DATA_W'(st_pending);
          default:     r.read_data = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (idx)
          REG_MODE:    st_mode = wd & PAIR_MASK;
          REG_OTYPE:   st_otype = wpins;
          REG_SPEED:   st_speed = wd & PAIR_MASK;
          REG_PULL:    st_pull = wd & PAIR_MASK;
          REG_OUTPUT:  st_output = wpins;
          REG_AFL:     st_afl = wd & AFL_MASK;
          REG_AFH:     st_afh = wd & AFH_MASK;
          REG_RISE:    st_rise = wpins;
          REG_FALL:    st_fall = wpins;
          REG_MASK:    st_mask = wpins;
          REG_PENDING: st_pending = st_pending & ~wpins;
          default: ;
        endcase
      end
      FUNC_SAMPLE: begin
        edges = (lvls & ~st_prev & st_rise) | (st_prev & ~lvls & st_fall);
        st_pending = (st_pending | edges) & PIN_MASK;
        st_input = lvls;
        st_prev = lvls;
      end
      default: ;
    endcase
    r.irq = |(st_pending & st_mask);
    r.pin_drive = st_output;
    r.open_drain = st_otype;
    for (int p = 0; p < PIN_COUNT; p++) begin
      pm = st_mode[2*p +: 2];
      r.drive_enable[p] = (pm == MODE_OUTPUT) || (pm == MODE_ALTFN);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] wd, input logic [PINS_W-1:0] lv);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    reg_index <= idx;
    write_data <= wd;
    pin_levels <= lv;
    do @(posedge clk); while (in_stall);
    awaited.push_back(port_access(f, idx, wd, lv));
  endtask

  task automatic send_random_item();
    int                pick;
    logic [FUNC_W-1:0] f;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wd;
    logic [PINS_W-1:0] lv;
    pick = $urandom_range(0, 99);
    wd = $urandom;
    lv = PINS_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      idx = IDX_W'($urandom_range(IDX_UNUSED_LO, IDX_UNUSED_HI));
    end else begin
      idx = IDX_W'($urandom_range(REG_MODE, REG_PENDING));
    end
    if (pick < 30) begin
      f = FUNC_READ;
    end else if (pick < 60) begin
      f = FUNC_WRITE;
    end else if (pick < 97) begin
      f = FUNC_SAMPLE;
      // single-pin toggles give clean isolated edges
      if ($urandom_range(0, 1)) lv = st_prev ^ (PINS_W'(1) << $urandom_range(0, PINS_W - 1));
    end else begin
      f = FUNC_NONE;
    end
    send_item(f, idx, wd, lv);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
  endtask

  task automatic test_register_access();
    send_item(FUNC_WRITE, REG_MODE, 32'hFFFF_FFFF, '0);
    send_item(FUNC_WRITE, REG_MODE, 32'h9999_9999, '0);
    send_item(FUNC_READ, REG_MODE, '0, '0);
    send_item(FUNC_WRITE, REG_OTYPE, 32'hFFFF_FFFF, '0);
    send_item(FUNC_WRITE, REG_OUTPUT, 32'hFFFF_FFFF, '0);
    send_item(FUNC_READ, REG_OUTPUT, '0, '0);
    send_item(FUNC_WRITE, REG_AFL, 32'hFFFF_FFFF, '0);
    send_item(FUNC_WRITE, REG_AFH, 32'hFFFF_FFFF, '0);
    send_item(FUNC_READ, REG_AFH, '0, '0);
    send_item(FUNC_WRITE, REG_SPEED, 32'hFFFF_FFFF, '0);
    send_item(FUNC_WRITE, REG_PULL, 32'hFFFF_FFFF, '0);
  endtask

  task automatic test_readonly_and_unused();
    send_item(FUNC_WRITE, REG_INPUT, 32'hFFFF_FFFF, '0);
    send_item(FUNC_READ, REG_INPUT, '0, '0);
    send_item(FUNC_WRITE, IDX_UNUSED_HI, 32'hFFFF_FFFF, '0);
    send_item(FUNC_READ, IDX_UNUSED_HI, '0, '0);
    send_item(FUNC_READ, IDX_UNUSED_LO, '0, '0);
    send_item(FUNC_NONE, REG_PULL, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_edge_latch();
    send_item(FUNC_WRITE, REG_RISE, 32'hFFFF_FFFF, '0);
    send_item(FUNC_WRITE, REG_FALL, 32'hFFFF_FFFF, '0);
    // edges latch even with every line masked
    send_item(FUNC_SAMPLE, REG_MODE, '0, 16'hFFFF);
    send_item(FUNC_WRITE, REG_MASK, 32'hFFFF_FFFF, '0);
    send_item(FUNC_WRITE, REG_PENDING, 32'h0000_00FF, '0);
    send_item(FUNC_READ, REG_PENDING, '0, '0);
    send_item(FUNC_SAMPLE, REG_MODE, '0, 16'h0000);
    send_item(FUNC_WRITE, REG_PENDING, 32'hFFFF_FFFF, '0);
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 7; chunk++) begin
      tx_idle = (chunk == 0) ? 1'b1 : (chunk == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_idle = (chunk == 0) ? 1'b1 : (chunk == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      repeat (RANDOM_ITEMS / 7) send_random_item();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_hold_cycles = 80;
    repeat (24) send_random_item();
    tx_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (40) send_random_item();
    wait_all_results();
    repeat (40) send_random_item();
  endtask

  initial begin : drain_results
    int hold;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      hold = rx_idle ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && rx_hold_cycles == 0);
    end
  end

  always @(posedge clk) begin : check_results
    port_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        report_mismatch("transfer with no result awaited", read_data, '0);
      end else begin
        want = awaited.pop_front();
        if (read_data !== want.read_data)
          report_mismatch("read_data", read_data, want.read_data);
        if (irq !== want.irq)
          report_mismatch("irq", DATA_W'(irq), DATA_W'(want.irq));
        if (pin_drive !== want.pin_drive)
          report_mismatch("pin_drive", DATA_W'(pin_drive), DATA_W'(want.pin_drive));
        if (drive_enable !== want.drive_enable)
          report_mismatch("drive_enable", DATA_W'(drive_enable), DATA_W'(want.drive_enable));
        if (open_drain !== want.open_drain)
          report_mismatch("open_drain", DATA_W'(open_drain), DATA_W'(want.open_drain));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_readonly_and_unused();
    test_edge_latch();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();
    wait_all_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gpioei_pkg.sv
rtl/gpio_port_with_edge_interrupts_core.sv
sim/tb_gpio_port_with_edge_interrupts_core.sv
